// ----- rtl/ray_box_slab_intersection_defines.svh -----
// assertion macros shared by the ray box slab intersection rtl
// no dependencies
`ifndef RAY_BOX_SLAB_INTERSECTION_DEFINES_SVH
`define RAY_BOX_SLAB_INTERSECTION_DEFINES_SVH

// implication checked every clock outside reset
`define RBS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the next cycle
`define RBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rbs_pkg.sv -----
// shared constants and types for the ray box slab intersection block
// no dependencies
`timescale 1ns / 1ps

package rbs_pkg;

  localparam int CoordWidth = 32;
  localparam int FracBits   = 16;
  // difference of two coordinates is one bit wider
  localparam int DiffWidth  = CoordWidth + 1;
  // dividend magnitude: difference shifted by the fraction bits
  localparam int NumWidth   = DiffWidth + FracBits;
  // quotient bits kept before the saturation check
  localparam int QuoWidth   = NumWidth;
  // pipeline depth of the divider: one quotient bit a stage
  localparam int DivStages  = QuoWidth;
  localparam int NumLanes   = 6;

  typedef logic signed [CoordWidth-1:0] coord_t;

  localparam coord_t CoordMax = coord_t'({1'b0, {(CoordWidth-1){1'b1}}});
  localparam coord_t CoordMin = coord_t'({1'b1, {(CoordWidth-1){1'b0}}});

  // per-item side information carried beside the lanes
  typedef struct packed {
    logic [2:0] zero_dir;
    logic       miss;
  } rbs_side_t;

endpackage

// ----- rtl/rbs_div_lane.sv -----
// pipelined restoring divider lane, one quotient bit per stage, saturating
// depends on rbs_pkg
`timescale 1ns / 1ps

module rbs_div_lane
  import rbs_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic signed [DiffWidth-1:0] in_num,
  input  coord_t                      in_den,
  output logic                        out_valid,
  output coord_t                      out_quo
);

  localparam int DenWidth = CoordWidth;
  // partial remainder never exceeds the divisor magnitude
  localparam int RemWidth = DenWidth + 1;

  logic [DivStages:0]                 vld_r;
  logic [NumWidth-1:0]                num_r [DivStages+1];
  logic [QuoWidth-1:0]                quo_r [DivStages+1];
  logic [RemWidth-1:0]                rem_r [DivStages+1];
  logic [DenWidth-1:0]                den_r [DivStages+1];
  logic                               neg_r [DivStages+1];

  logic [DiffWidth-1:0] num_mag;
  logic [DenWidth-1:0]  den_mag;
  logic                 sat;
  logic [CoordWidth-1:0] qpos;

  // magnitudes and sign at the lane entry
  always_comb begin
    num_mag = in_num[DiffWidth-1] ? DiffWidth'(-in_num) : DiffWidth'(in_num);
    den_mag = in_den[CoordWidth-1] ? DenWidth'(-in_den) : DenWidth'(in_den);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else vld_r[0] <= in_valid;
    num_r[0] <= {num_mag, {FracBits{1'b0}}};
    quo_r[0] <= '0;
    rem_r[0] <= '0;
    den_r[0] <= den_mag;
    neg_r[0] <= in_num[DiffWidth-1] ^ in_den[CoordWidth-1];
  end

  // one restoring step per stage
  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic [RemWidth:0] trial;
    logic              ge;
    always_comb begin
      trial = {rem_r[s], num_r[s][NumWidth-1]};
      ge    = trial >= {2'b00, den_r[s]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[s+1] <= 1'b0;
      else vld_r[s+1] <= vld_r[s];
      num_r[s+1] <= {num_r[s][NumWidth-2:0], 1'b0};
      rem_r[s+1] <= ge ? RemWidth'(trial - {2'b00, den_r[s]}) : RemWidth'(trial);
      quo_r[s+1] <= {quo_r[s][QuoWidth-2:0], ge};
      den_r[s+1] <= den_r[s];
      neg_r[s+1] <= neg_r[s];
    end
  end

  // saturate to the coordinate range
  always_comb begin
    sat  = |quo_r[DivStages][QuoWidth-1:CoordWidth-1];
    qpos = quo_r[DivStages][CoordWidth-1:0];
    if (sat) out_quo = neg_r[DivStages] ? CoordMin : CoordMax;
    else out_quo = neg_r[DivStages] ? coord_t'(-qpos) : coord_t'(qpos);
  end
  assign out_valid = vld_r[DivStages];

endmodule

// ----- rtl/rbs_merge.sv -----
// merging stage: sorts slab pairs and reduces to entry, exit and hit
// depends on rbs_pkg
`timescale 1ns / 1ps

module rbs_merge
  import rbs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  coord_t    in_t [NumLanes],
  input  rbs_side_t in_side,
  output logic      out_strobe,
  output logic      out_hit,
  output coord_t    out_entry
);

  coord_t near_a [3];
  coord_t far_a  [3];
  coord_t near_r [3];
  coord_t far_r  [3];
  logic   miss_r, vld_r;
  coord_t entry_c, exit_c;
  logic   hit_c;
  logic   strobe_r, hit_r;
  coord_t entry_r;

  // sort each axis, open slab for zero direction
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (in_side.zero_dir[a]) begin
        near_a[a] = CoordMin;
        far_a[a]  = CoordMax;
      end else if (in_t[2*a] < in_t[2*a+1]) begin
        near_a[a] = in_t[2*a];
        far_a[a]  = in_t[2*a+1];
      end else begin
        near_a[a] = in_t[2*a+1];
        far_a[a]  = in_t[2*a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= in_valid;
    near_r <= near_a;
    far_r  <= far_a;
    miss_r <= in_side.miss;
  end

  // max of near, min of far
  always_comb begin
    entry_c = near_r[0];
    exit_c  = far_r[0];
    for (int a = 1; a < 3; a++) begin
      if (near_r[a] > entry_c) entry_c = near_r[a];
      if (far_r[a] < exit_c) exit_c = far_r[a];
    end
    hit_c = !miss_r && (exit_c >= entry_c) && !exit_c[CoordWidth-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) strobe_r <= 1'b0;
    else strobe_r <= vld_r;
    hit_r   <= hit_c;
    entry_r <= hit_c ? entry_c : '0;
  end

  assign out_strobe = strobe_r;
  assign out_hit    = hit_r;
  assign out_entry  = entry_r;

endmodule

// ----- rtl/ray_box_slab_intersection.sv -----
// top level of the ray versus axis-aligned box slab test
// depends on rbs_pkg, rbs_div_lane, rbs_merge and the defines header
//
// usage: drive the twelve in_ fields (signed Q16.16) and pulse start; a
// request is taken at each clock edge with start high and busy low. busy
// is tied low, so a new request may enter every cycle.
// six divider lanes form the slab distances (bound - origin) / direction
// for both bounds of all three axes side by side; each lane is an input
// register followed by a 49-stage pipeline resolving one quotient bit per
// stage. a merging stage then sorts each pair and reduces them to entry
// and exit over two more registers.
// throughput: one request per cycle, results in request order.
// results appear for exactly one cycle on out_hit and out_entry_distance
// with out_strobe high; the receiver cannot stall. entry is zero on miss.
// reset (rst_n low, synchronous) drops every request in flight.
`timescale 1ns / 1ps
`include "ray_box_slab_intersection_defines.svh"

module ray_box_slab_intersection
  import rbs_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  output logic   busy,
  input  coord_t in_origin_x,
  input  coord_t in_origin_y,
  input  coord_t in_origin_z,
  input  coord_t in_dir_x,
  input  coord_t in_dir_y,
  input  coord_t in_dir_z,
  input  coord_t in_box_min_x,
  input  coord_t in_box_min_y,
  input  coord_t in_box_min_z,
  input  coord_t in_box_max_x,
  input  coord_t in_box_max_y,
  input  coord_t in_box_max_z,
  output logic   out_strobe,
  output logic   out_hit,
  output coord_t out_entry_distance
);

  localparam int SideDepth = DivStages + 1;

  logic   accept;
  coord_t org [3];
  coord_t dir [3];
  coord_t bmin [3];
  coord_t bmax [3];
  logic signed [DiffWidth-1:0] num [NumLanes];
  coord_t den [NumLanes];
  coord_t quo [NumLanes];
  logic [NumLanes-1:0] lane_vld;
  rbs_side_t side_in;
  rbs_side_t side_r [SideDepth];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign org  = '{in_origin_x, in_origin_y, in_origin_z};
  assign dir  = '{in_dir_x, in_dir_y, in_dir_z};
  assign bmin = '{in_box_min_x, in_box_min_y, in_box_min_z};
  assign bmax = '{in_box_max_x, in_box_max_y, in_box_max_z};

  // lane operands and zero-direction checks
  always_comb begin
    side_in.miss = 1'b0;
    for (int a = 0; a < 3; a++) begin
      num[2*a]   = DiffWidth'(bmin[a]) - DiffWidth'(org[a]);
      num[2*a+1] = DiffWidth'(bmax[a]) - DiffWidth'(org[a]);
      den[2*a]   = dir[a];
      den[2*a+1] = dir[a];
      side_in.zero_dir[a] = dir[a] == '0;
      if (side_in.zero_dir[a] && (org[a] < bmin[a] || org[a] > bmax[a]))
        side_in.miss = 1'b1;
    end
  end

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    rbs_div_lane u_lane (
      .clk(clk), .rst_n(rst_n), .in_valid(accept), .in_num(num[l]),
      .in_den(den[l]), .out_valid(lane_vld[l]), .out_quo(quo[l])
    );
  end

  // side information delay line matching the lanes
  always_ff @(posedge clk) begin
    side_r[0] <= side_in;
    for (int s = 1; s < SideDepth; s++) side_r[s] <= side_r[s-1];
  end

  rbs_merge u_merge (
    .clk(clk), .rst_n(rst_n), .in_valid(lane_vld[0]), .in_t(quo),
    .in_side(side_r[SideDepth-1]), .out_strobe(out_strobe),
    .out_hit(out_hit), .out_entry(out_entry_distance)
  );

  `RBS_ASSERT_IMP(a_lanes_agree, lane_vld[0], &lane_vld, "divider lanes out of step")
  `RBS_ASSERT_IMP(a_miss_zero, out_strobe && !out_hit, out_entry_distance == '0,
    "miss with nonzero entry")
  `RBS_ASSERT_NEXT(a_never_busy, 1'b1, !busy, "busy raised")

endmodule
